/* hdl/sha1he_pkg.sv */
// ----------------------------------------------------------------------------
// sha1he_pkg
// Shared types and constants of the SHA-1 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package sha1he_pkg;

   // input word: message bytes, big-endian, first byte in [31:24]
   typedef struct packed {
      logic [31:0] data_word;
      logic [2:0]  byte_count;
      logic        last;
   } req_type;

   // result word: one digest word
   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b0000001,
      ST_INSERT   = 7'b0000010,
      ST_COMPRESS = 7'b0000100,
      ST_FOLD     = 7'b0001000,
      ST_PAD      = 7'b0010000,
      ST_PAD2     = 7'b0100000,
      ST_EMIT     = 7'b1000000
   } state_type;

   typedef enum logic [2:0] {
      BUF_HOLD,
      BUF_DATA,
      BUF_PAD_HEAD,
      BUF_PAD_TAIL,
      BUF_SHIFT
   } buf_op_type;

   typedef struct packed {
      buf_op_type  op;
      logic [5:0]  pos;
      logic [2:0]  n;
      logic [31:0] data;
      logic [63:0] bit_len;
   } buf_cmd_type;

   typedef struct packed {
      logic load;
      logic step;
      logic fold;
      logic init;
   } rnd_cmd_type;

   localparam logic [31:0] INIT_CHAIN [5] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   localparam logic [31:0] K0 = 32'h5A827999;
   localparam logic [31:0] K1 = 32'h6ED9EBA1;
   localparam logic [31:0] K2 = 32'h8F1BBCDC;
   localparam logic [31:0] K3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_BYTE    = 8'h80;
   localparam logic [6:0] ROUNDS      = 7'd80;
   localparam logic [6:0] BLOCK_BYTES = 7'd64;
   localparam logic [5:0] LEN_POS     = 6'd56;
   localparam logic [2:0] LAST_INDEX  = 3'd4;

endpackage

`default_nettype wire

/* hdl/sha1he_msg_buf.sv */
// ----------------------------------------------------------------------------
// sha1he_msg_buf
// 64-byte block buffer; byte-granular fill and padding, then runs as the
// 16-word message schedule window during compression.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1he_msg_buf
   import sha1he_pkg::*;
(
   input  wire logic        clock,
   input  wire buf_cmd_type cmd,
   output logic [31:0]      sched_word
);

   logic [31:0] buf_ff [16];
   logic [31:0] buf_in [16];

   always_comb begin
      logic [5:0]  jb;
      logic [5:0]  d;
      logic [7:0]  b;
      logic        wr;
      logic [31:0] x;
      buf_in = buf_ff;
      x = buf_ff[13] ^ buf_ff[8] ^ buf_ff[2] ^ buf_ff[0];
      if (cmd.op == BUF_SHIFT) begin
         for (int i = 0; i < 15; i++) begin
            buf_in[i] = buf_ff[i + 1];
         end
         buf_in[15] = {x[30:0], x[31]};
      end
      for (int j = 0; j < 64; j++) begin
         jb = 6'(j);
         d  = jb - cmd.pos;
         wr = 1'b0;
         b  = 8'h00;
         unique case (cmd.op)
            BUF_DATA: begin
               if (d < {3'b000, cmd.n}) begin
                  wr = 1'b1;
                  b  = cmd.data[{~d[1:0], 3'b000} +: 8];
               end
            end
            BUF_PAD_HEAD: begin
               if (jb == cmd.pos) begin
                  wr = 1'b1;
                  b  = PAD_BYTE;
               end else if (jb > cmd.pos) begin
                  wr = 1'b1;
                  if (jb >= LEN_POS && cmd.pos < LEN_POS) begin
                     b = cmd.bit_len[{~jb[2:0], 3'b000} +: 8];
                  end
               end
            end
            BUF_PAD_TAIL: begin
               wr = 1'b1;
               if (jb >= LEN_POS) begin
                  b = cmd.bit_len[{~jb[2:0], 3'b000} +: 8];
               end
            end
            BUF_HOLD, BUF_SHIFT: begin
               wr = 1'b0;
            end
            default: begin
               wr = 1'b0;
            end
         endcase
         if (wr) begin
            buf_in[jb[5:2]][{~jb[1:0], 3'b000} +: 8] = b;
         end
      end
   end

   always_ff @(posedge clock) begin
      buf_ff <= buf_in;
   end

   assign sched_word = buf_ff[0];

endmodule

`default_nettype wire

/* hdl/sha1he_round.sv */
// ----------------------------------------------------------------------------
// sha1he_round
// Shared SHA-1 round unit: working registers a..e, one round per step,
// and the chain value with its fold-in adders.
// ----------------------------------------------------------------------------
`default_nettype none

module sha1he_round
   import sha1he_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire rnd_cmd_type cmd,
   input  wire logic [6:0]  round,
   input  wire logic [31:0] sched_word,
   input  wire logic [2:0]  rd_idx,
   output logic [31:0]      rd_data
);

   logic [31:0] chain_ff [5];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0] f, k, t;

   always_comb begin
      priority if (round < 7'd20) begin
         f = (b_ff & c_ff) | (~b_ff & d_ff);
         k = K0;
      end else if (round < 7'd40) begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K1;
      end else if (round < 7'd60) begin
         f = (b_ff & c_ff) | (b_ff & d_ff) | (c_ff & d_ff);
         k = K2;
      end else begin
         f = b_ff ^ c_ff ^ d_ff;
         k = K3;
      end
      t = {a_ff[26:0], a_ff[31:27]} + f + e_ff + k + sched_word;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         a_ff <= chain_ff[0];
         b_ff <= chain_ff[1];
         c_ff <= chain_ff[2];
         d_ff <= chain_ff[3];
         e_ff <= chain_ff[4];
      end else if (cmd.step) begin
         a_ff <= t;
         b_ff <= a_ff;
         c_ff <= {b_ff[1:0], b_ff[31:2]};
         d_ff <= c_ff;
         e_ff <= d_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.init) begin
         chain_ff <= INIT_CHAIN;
      end else if (cmd.fold) begin
         chain_ff[0] <= chain_ff[0] + a_ff;
         chain_ff[1] <= chain_ff[1] + b_ff;
         chain_ff[2] <= chain_ff[2] + c_ff;
         chain_ff[3] <= chain_ff[3] + d_ff;
         chain_ff[4] <= chain_ff[4] + e_ff;
      end
   end

   always_comb begin
      unique case (rd_idx)
         3'd0:    rd_data = chain_ff[0];
         3'd1:    rd_data = chain_ff[1];
         3'd2:    rd_data = chain_ff[2];
         3'd3:    rd_data = chain_ff[3];
         3'd4:    rd_data = chain_ff[4];
         default: rd_data = 32'h0;
      endcase
   end

endmodule

`default_nettype wire

/* hdl/sha1_hash_engine.sv */
// ----------------------------------------------------------------------------
// sha1_hash_engine
// SHA-1 over a byte stream of big-endian words with 0..4 valid bytes each.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle while the block buffer fills; each full
//   64-byte block then stalls the input for its 80 rounds on the one
//   shared round unit and the chain fold, and for one more insert step
//   when a word straddles the block boundary.
// Last word: the padding block is compressed (and a second block if the
//   length does not fit), the first digest word is loaded, then five digest
//   words follow, one per cycle without stalls.
// Reset: synchronous, active high; chain value to the SHA-1 initial value,
//   buffer fill and bit length to zero, engine idle and ready.
`default_nettype none

module sha1_hash_engine
   import sha1he_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_word,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_word
);

   // control and progress registers
   state_type   state_ff, state_in;
   state_type   ret_ff, ret_in;       // where to go after the chain fold
   logic [5:0]  pos_ff, pos_in;       // bytes held in the block buffer
   logic [63:0] len_ff, len_in;       // message length in bits
   logic [6:0]  round_ff, round_in;
   logic [2:0]  idx_ff, idx_in;       // digest word on display
   logic        rsp_valid_ff, rsp_valid_in;

   // leftover of a word that straddled a block boundary
   logic [31:0] word_ff, word_in;
   logic [2:0]  rem_ff, rem_in;
   logic        last_ff, last_in;
   rsp_type     rsp_ff, rsp_in;

   buf_cmd_type bcmd;
   rnd_cmd_type rcmd;
   logic [31:0] sched_word;
   logic [2:0]  rd_idx;
   logic [31:0] rd_data;

   // byte insertion: take as many bytes as fit in the current block
   logic        ins_go;
   logic [31:0] src_word;
   logic [2:0]  src_cnt;
   logic        src_last;
   logic [2:0]  req_cnt;
   logic [6:0]  ins_space;
   logic [2:0]  ins_n;
   logic [6:0]  ins_fill;
   logic        ins_full;
   logic [2:0]  rem_left;
   logic [31:0] word_left;

   assign req_cnt   = (req_word.byte_count > 3'd4) ? 3'd4 : req_word.byte_count;
   assign ins_go    = (state_ff == ST_IDLE && req_valid) || state_ff == ST_INSERT;
   assign src_word  = (state_ff == ST_IDLE) ? req_word.data_word : word_ff;
   assign src_cnt   = (state_ff == ST_IDLE) ? req_cnt : rem_ff;
   assign src_last  = (state_ff == ST_IDLE) ? req_word.last : last_ff;
   assign ins_space = BLOCK_BYTES - {1'b0, pos_ff};
   assign ins_n     = ({4'b0000, src_cnt} > ins_space) ? ins_space[2:0] : src_cnt;
   assign ins_fill  = {1'b0, pos_ff} + {4'b0000, ins_n};
   assign ins_full  = ins_fill[6];
   assign rem_left  = src_cnt - ins_n;
   assign word_left = src_word << {ins_n, 3'b000};

   // read the next digest word while the current one is taken
   assign rd_idx = rsp_valid_ff ? (idx_ff + 3'd1) : idx_ff;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      round_in     = round_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      word_in      = word_ff;
      rem_in       = rem_ff;
      last_in      = last_ff;
      rsp_in       = rsp_ff;
      bcmd.op      = BUF_HOLD;
      bcmd.pos     = pos_ff;
      bcmd.n       = ins_n;
      bcmd.data    = src_word;
      bcmd.bit_len = len_ff;
      rcmd         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               len_in = len_ff + {58'd0, req_cnt, 3'b000};
            end
         end
         ST_INSERT: begin
            // handled with the insertion path below
         end
         ST_COMPRESS: begin
            rcmd.step = 1'b1;
            bcmd.op   = BUF_SHIFT;
            if (round_ff == ROUNDS - 7'd1) begin
               round_in = 7'd0;
               state_in = ST_FOLD;
            end else begin
               round_in = round_ff + 7'd1;
            end
         end
         ST_FOLD: begin
            rcmd.fold = 1'b1;
            idx_in    = 3'd0;
            state_in  = ret_ff;
         end
         ST_PAD: begin
            // 0x80, zeros, and the length too if it still fits
            bcmd.op   = BUF_PAD_HEAD;
            rcmd.load = 1'b1;
            round_in  = 7'd0;
            pos_in    = 6'd0;
            state_in  = ST_COMPRESS;
            ret_in    = (pos_ff < LEN_POS) ? ST_EMIT : ST_PAD2;
         end
         ST_PAD2: begin
            bcmd.op   = BUF_PAD_TAIL;
            rcmd.load = 1'b1;
            round_in  = 7'd0;
            state_in  = ST_COMPRESS;
            ret_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in       = 1'b1;
               rsp_in.digest_word = rd_data;
               rsp_in.word_index  = idx_ff;
               rsp_in.last_word   = (idx_ff == LAST_INDEX);
            end else if (!rsp_stall) begin
               if (idx_ff == LAST_INDEX) begin
                  // digest done: fresh message
                  rsp_valid_in = 1'b0;
                  rcmd.init    = 1'b1;
                  len_in       = 64'd0;
                  pos_in       = 6'd0;
                  state_in     = ST_IDLE;
               end else begin
                  idx_in             = idx_ff + 3'd1;
                  rsp_in.digest_word = rd_data;
                  rsp_in.word_index  = idx_ff + 3'd1;
                  rsp_in.last_word   = (idx_ff + 3'd1 == LAST_INDEX);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (ins_go) begin
         bcmd.op = BUF_DATA;
         word_in = word_left;
         rem_in  = rem_left;
         last_in = src_last;
         if (ins_full) begin
            // block complete: start the rounds, resume afterwards
            pos_in    = 6'd0;
            rcmd.load = 1'b1;
            round_in  = 7'd0;
            state_in  = ST_COMPRESS;
            if (rem_left != 3'd0) begin
               ret_in = ST_INSERT;
            end else if (src_last) begin
               ret_in = ST_PAD;
            end else begin
               ret_in = ST_IDLE;
            end
         end else begin
            pos_in   = ins_fill[5:0];
            state_in = src_last ? ST_PAD : ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         pos_ff       <= 6'd0;
         len_ff       <= 64'd0;
         round_ff     <= 7'd0;
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         pos_ff       <= pos_in;
         len_ff       <= len_in;
         round_ff     <= round_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
      rem_ff  <= rem_in;
      last_ff <= last_in;
      rsp_ff  <= rsp_in;
   end

   sha1he_msg_buf u_msg_buf (
      .clock      (clock),
      .cmd        (bcmd),
      .sched_word (sched_word)
   );

   sha1he_round u_round (
      .clock      (clock),
      .reset      (reset),
      .cmd        (rcmd),
      .round      (round_ff),
      .sched_word (sched_word),
      .rd_idx     (rd_idx),
      .rd_data    (rd_data)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

endmodule

`default_nettype wire

/* dv/sha1_hash_engine_tb.sv */
// ----------------------------------------------------------------------------
// sha1_hash_engine_tb
// Self-checking bench for the SHA-1 engine: byte messages go in as words of
// 0..4 bytes, and a local SHA-1 model predicts the five digest words of each.
// ----------------------------------------------------------------------------
module sha1_hash_engine_tb;
   import sha1he_pkg::*;

   localparam int unsigned ITEM_TARGET    = 480;
   localparam int unsigned MAX_WAIT       = 13;
   // Worst case with nothing moving: padding over two blocks plus a stalled
   // receiver, so this is many times the slowest correct stretch.
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 200;
   localparam int unsigned REPORT_LIMIT   = 10;

   // -------------------------------------------------------------------------
   // Digest predictor and store of expected digest words.
   // Keeps its own chain value, 64-byte block and bit count; a last word
   // pads the message and queues the five words of the digest.
   // -------------------------------------------------------------------------
   class digest_scoreboard;
      bit [31:0]   chain [5];
      bit [7:0]    block [64];
      int unsigned fill;
      bit [63:0]   bit_len;
      rsp_type     digest_q [$];
      int unsigned fail_count;

      function new();
         fail_count = 0;
         restart();
      endfunction

      function void restart();
         chain[0] = 32'h67452301;
         chain[1] = 32'hEFCDAB89;
         chain[2] = 32'h98BADCFE;
         chain[3] = 32'h10325476;
         chain[4] = 32'hC3D2E1F0;
         fill     = 0;
         bit_len  = '0;
      endfunction

      // 80 rounds over the current block, folded into the chain value
      function void compress();
         bit [31:0] sched [80];
         bit [31:0] a, b, c, d, e, f, k, t, mix;
         for (int i = 0; i < 16; i++) begin
            sched[i] = {block[4*i], block[4*i+1], block[4*i+2], block[4*i+3]};
         end
         for (int i = 16; i < 80; i++) begin
            mix      = sched[i-3] ^ sched[i-8] ^ sched[i-14] ^ sched[i-16];
            sched[i] = {mix[30:0], mix[31]};
         end
         a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
         for (int r = 0; r < 80; r++) begin
            case (r / 20)
               0: begin
                  f = (b & c) | (~b & d);
                  k = 32'h5A827999;
               end
               1: begin
                  f = b ^ c ^ d;
                  k = 32'h6ED9EBA1;
               end
               2: begin
                  f = (b & c) | (b & d) | (c & d);
                  k = 32'h8F1BBCDC;
               end
               default: begin
                  f = b ^ c ^ d;
                  k = 32'hCA62C1D6;
               end
            endcase
            t = {a[26:0], a[31:27]} + f + e + k + sched[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
         end
         chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
      endfunction

      function void push_byte(bit [7:0] value);
         block[fill] = value;
         fill++;
         if (fill == 64) begin
            compress();
            fill = 0;
         end
      endfunction

      function void note_word(req_type w);
         int unsigned n;
         bit [63:0]   total;
         rsp_type     item;
         n = (w.byte_count > 4) ? 4 : w.byte_count;
         for (int i = 0; i < n; i++) begin
            push_byte(w.data_word[31-8*i -: 8]);
            bit_len += 64'd8;
         end
         if (w.last) begin
            total = bit_len;
            push_byte(8'h80);
            while (fill != 56) push_byte(8'h00);
            for (int i = 0; i < 8; i++) push_byte(total[63-8*i -: 8]);
            for (int i = 0; i < 5; i++) begin
               item.digest_word = chain[i];
               item.word_index  = 3'(i);
               item.last_word   = (i == 4);
               digest_q.push_back(item);
            end
            restart();
         end
      endfunction

      function void check_digest(rsp_type got);
         rsp_type want;
         if (digest_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("unexpected digest word %h index %0d last %0d",
                        got.digest_word, got.word_index, got.last_word);
            return;
         end
         want = digest_q.pop_front();
         if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
             got.last_word !== want.last_word) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT)
               $display("digest mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
                        want.digest_word, want.word_index, want.last_word,
                        got.digest_word, got.word_index, got.last_word);
         end
      endfunction

      function int unsigned pending();
         return digest_q.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and DUT
   // -------------------------------------------------------------------------
   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   digest_scoreboard sb = new();
   int unsigned      words_sent  = 0;
   int unsigned      idle_cycles = 0;
   bit               quiet       = 1'b0;   // no idling on either side while set

   always #4 clock = ~clock;

   sha1_hash_engine DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // -------------------------------------------------------------------------
   // Word driver. Valid stays high straight into the next word when no gap
   // is drawn, so valid is never dropped and raised in the same step.
   // -------------------------------------------------------------------------
   task automatic drive_word(input req_type w);
      int unsigned gap;
      gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
      sb.note_word(w);
      words_sent++;
   endtask

   task automatic drive_fields(input logic [31:0] data, input logic [2:0] count,
                               input logic is_last);
      req_type w;
      w.data_word  = data;
      w.byte_count = count;
      w.last       = is_last;
      drive_word(w);
   endtask

   // Message of n_full words, then a last word of tail bytes. A noisy
   // message slips in short or oversized middle words.
   task automatic send_message(input int unsigned n_full, input int unsigned tail,
                               input bit noisy);
      logic [2:0] count;
      for (int i = 0; i < n_full; i++) begin
         count = (noisy && $urandom_range(0, 4) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
         drive_fields($urandom, count, 1'b0);
      end
      drive_fields($urandom, 3'(tail), 1'b1);
   endtask

   // -------------------------------------------------------------------------
   // Digest collector: random stall before each word, none while quiet
   // -------------------------------------------------------------------------
   initial begin : collect
      int unsigned hold;
      forever begin
         hold = quiet ? 0 : $urandom_range(0, MAX_WAIT);
         if (hold != 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         sb.check_digest(rsp_word);
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: cycles in which neither channel moves a word
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned n_full;
      int unsigned tail;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // empty message: padding and length only
      drive_fields(32'h00000000, 3'd0, 1'b1);
      // "abc" with junk in the unused low byte
      drive_fields(32'h616263DD, 3'd3, 1'b1);
      drive_fields(32'hFFFFFFFF, 3'd4, 1'b1);
      // oversized byte count on a last word counts as four
      drive_fields(32'h00000000, 3'd7, 1'b1);
      // short, empty and oversized words in the middle of a message just append
      drive_fields(32'hA5123456, 3'd1, 1'b0);
      drive_fields(32'h5A5AFFFF, 3'd2, 1'b0);
      drive_fields(32'h12345678, 3'd6, 1'b0);
      drive_fields(32'hFFFFFFFF, 3'd0, 1'b0);
      drive_fields(32'hFFFFFFFF, 3'd5, 1'b1);
      // 55 bytes: 0x80 and the length just fit in one block
      for (int i = 0; i < 13; i++) drive_fields(32'h00010203 + 32'h04040404 * i, 3'd4, 1'b0);
      drive_fields(32'h3435367F, 3'd3, 1'b1);

      // random messages; lengths cross the 56- and 64-byte padding boundaries
      while (words_sent < ITEM_TARGET) begin
         quiet  = ($urandom_range(0, 4) == 0);
         n_full = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 4) : $urandom_range(0, 35);
         tail   = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
         send_message(n_full, tail, $urandom_range(0, 3) == 0);
      end
      req_valid <= 1'b0;

      // drain outstanding digests, then give a stray word time to show
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.fail_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
